// File: hdl/afpf_pkg.sv
// Package for the AX.25 frame parser and address filter.
// Holds the word types, the configuration layout, register indexes and status codes.
// No dependencies.
package afpf_pkg;

	localparam int unsigned DEF_MAX_FRAME = 1024;

	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned CHAR_W       = 7;
	localparam int unsigned NUM_CHARS    = 7;
	localparam int unsigned ADDR_W       = CHAR_W * NUM_CHARS;
	localparam int unsigned CHAR_IDX_W   = $clog2(NUM_CHARS);
	localparam int unsigned PLEN_W       = 10;
	localparam int unsigned CTRL_POS     = 14;
	localparam int unsigned PID_POS      = 15;
	localparam int unsigned HEADER_BYTES = 16;
	localparam int unsigned FCS_BYTES    = 2;
	localparam int unsigned MIN_FRAME    = HEADER_BYTES + FCS_BYTES;

	localparam logic [CHAR_IDX_W-1:0] LAST_CHAR = CHAR_IDX_W'(NUM_CHARS - 1);

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_SHORT = 2'd1;
	localparam logic [1:0] STATUS_LONG  = 2'd2;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_FILT_SRC_EN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILT_DST_EN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILT_CTRL_EN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILT_PID_EN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WANT_SRC     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WANT_DST     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WANT_CTRL    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WANT_PID     = 3'd7;

	// Character 0 sits in the top slot.
	typedef logic [NUM_CHARS-1:0][CHAR_W-1:0] addr_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic              end_of_frame;
	} in_word_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] payload_byte;
		logic [ADDR_W-1:0] destination_address;
		logic [ADDR_W-1:0] source_address;
		logic [BYTE_W-1:0] control_field;
		logic [BYTE_W-1:0] pid_field;
		logic [PLEN_W-1:0] payload_length;
		logic              rejected;
		logic [1:0]        status;
		logic              last;
	} out_word_t;

	typedef struct packed {
		logic              filt_src_en;
		logic              filt_dst_en;
		logic              filt_ctrl_en;
		logic              filt_pid_en;
		addr_t             want_src;
		addr_t             want_dst;
		logic [BYTE_W-1:0] want_ctrl;
		logic [BYTE_W-1:0] want_pid;
	} cfg_t;

	typedef struct packed {
		addr_t             dst;
		addr_t             src;
		logic [BYTE_W-1:0] ctrl;
		logic [BYTE_W-1:0] pid;
		logic [PLEN_W-1:0] length;
		logic [1:0]        status;
	} sum_t;

endpackage

// File: hdl/ax25_frame_parse_filter_top.sv
// Top level of the AX.25 frame parser with address, control and PID filter.
// Holds the configuration registers and the input register; uses afpf_pkg,
// afpf_parse, afpf_filter and afpf_outq.
//
// Channel  Dir  Handshake              Word
// in       in   in_valid / in_ready    in_word (frame_byte, end_of_frame)
// out      out  out_valid / out_ready  out_word (payload byte or frame summary)
// cfg      in   cfg_wr_en              cfg_index, cfg_wdata
//
// One frame byte is taken per cycle unless a stall or a waiting summary holds the input;
// the words it causes reach the output through the input register and the output register.
// A final byte that yields both a payload word and a summary holds the input while the
// summary waits in the second output slot.
// Reset clears the configuration and all frame state; there is no clearing pass.
// A stall on out_ready backs up through the output slots into the input register.
module ax25_frame_parse_filter_top #(
	parameter int unsigned MAX_FRAME = afpf_pkg::DEF_MAX_FRAME
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  afpf_pkg::in_word_t             in_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output afpf_pkg::out_word_t            out_word,
	input  logic                           cfg_wr_en,
	input  logic [afpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [afpf_pkg::ADDR_W-1:0]    cfg_wdata
);
	import afpf_pkg::*;

	cfg_t              cfg_q;
	logic              s1_v;
	in_word_t          item_s1;
	logic              can_take, take;
	logic              pay_valid, sum_valid;
	logic [BYTE_W-1:0] pay_byte;
	sum_t              sum;
	out_word_t         sum_word;

	assign take     = s1_v && can_take;
	assign in_ready = !s1_v || can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FILT_SRC_EN:  cfg_q.filt_src_en  <= cfg_wdata[0];
				REG_FILT_DST_EN:  cfg_q.filt_dst_en  <= cfg_wdata[0];
				REG_FILT_CTRL_EN: cfg_q.filt_ctrl_en <= cfg_wdata[0];
				REG_FILT_PID_EN:  cfg_q.filt_pid_en  <= cfg_wdata[0];
				REG_WANT_SRC:     cfg_q.want_src     <= cfg_wdata;
				REG_WANT_DST:     cfg_q.want_dst     <= cfg_wdata;
				REG_WANT_CTRL:    cfg_q.want_ctrl    <= cfg_wdata[BYTE_W-1:0];
				REG_WANT_PID:     cfg_q.want_pid     <= cfg_wdata[BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_v <= 1'b1;
		end else if (take) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_word;
		end
	end

	afpf_parse #(
		.MAX_FRAME(MAX_FRAME)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (item_s1),
		.pay_valid(pay_valid),
		.pay_byte (pay_byte),
		.sum_valid(sum_valid),
		.sum      (sum)
	);

	afpf_filter u_filter (
		.cfg (cfg_q),
		.sum (sum),
		.word(sum_word)
	);

	afpf_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_pay (pay_valid),
		.pay_byte (pay_byte),
		.push_sum (sum_valid),
		.sum_word (sum_word),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_word (out_word),
		.can_take (can_take)
	);

endmodule

// File: hdl/afpf_parse.sv
// Frame state: byte position, header capture, two-byte trailing delay and overflow flag.
// Produces the delayed payload byte and the frame summary fields for each word.
// Depends on afpf_pkg.
module afpf_parse #(
	parameter int unsigned MAX_FRAME = afpf_pkg::DEF_MAX_FRAME
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  afpf_pkg::in_word_t            item,
	output logic                          pay_valid,
	output logic [afpf_pkg::BYTE_W-1:0]   pay_byte,
	output logic                          sum_valid,
	output afpf_pkg::sum_t                sum
);
	import afpf_pkg::*;

	localparam int unsigned POS_W = $clog2(MAX_FRAME + 1);
	localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_FRAME);
	localparam logic [POS_W-1:0] POS_SRC  = POS_W'(NUM_CHARS);
	localparam logic [POS_W-1:0] POS_CTRL = POS_W'(CTRL_POS);
	localparam logic [POS_W-1:0] POS_PID  = POS_W'(PID_POS);
	localparam logic [POS_W-1:0] POS_MIN  = POS_W'(MIN_FRAME);

	logic [POS_W-1:0]  pos_q, pos_n;
	addr_t             dst_q, dst_n, src_q, src_n;
	logic [BYTE_W-1:0] ctrl_q, ctrl_n, pid_q, pid_n;
	logic [BYTE_W-1:0] td0_q, td0_n, td1_q, td1_n;
	logic              ovf_q, ovf_n;
	logic              in_range;
	logic [CHAR_W-1:0] ch;
	logic [CHAR_IDX_W-1:0] dst_idx, src_idx;

	always_comb begin
		in_range = pos_q < POS_MAX;
		ch       = item.frame_byte[BYTE_W-1:1];
		dst_idx  = CHAR_IDX_W'(pos_q);
		src_idx  = CHAR_IDX_W'(pos_q - POS_SRC);
		pos_n    = pos_q;
		dst_n    = dst_q;
		src_n    = src_q;
		ctrl_n   = ctrl_q;
		pid_n    = pid_q;
		td0_n    = td0_q;
		td1_n    = td1_q;
		ovf_n    = ovf_q;
		if (in_range) begin
			pos_n = pos_q + 1'b1;
			priority if (pos_q < POS_SRC) begin
				dst_n[LAST_CHAR - dst_idx] = ch;
			end else if (pos_q < POS_CTRL) begin
				src_n[LAST_CHAR - src_idx] = ch;
			end else if (pos_q == POS_CTRL) begin
				ctrl_n = item.frame_byte;
			end else if (pos_q == POS_PID) begin
				pid_n = item.frame_byte;
			end else begin
				td0_n = td1_q;
				td1_n = item.frame_byte;
			end
		end else begin
			ovf_n = 1'b1;
		end

		pay_valid = take && in_range && (pos_q >= POS_MIN);
		pay_byte  = td0_q;
		sum_valid = take && item.end_of_frame;

		sum.dst  = dst_n;
		sum.src  = src_n;
		sum.ctrl = ctrl_n;
		sum.pid  = pid_n;
		if (ovf_n) begin
			sum.status = STATUS_LONG;
		end else if (pos_n < POS_MIN) begin
			sum.status = STATUS_SHORT;
		end else begin
			sum.status = STATUS_OK;
		end
		sum.length = (pos_n >= POS_MIN) ? PLEN_W'(pos_n - POS_MIN) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			dst_q  <= '0;
			src_q  <= '0;
			ctrl_q <= '0;
			pid_q  <= '0;
			td0_q  <= '0;
			td1_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (take) begin
			if (item.end_of_frame) begin
				pos_q  <= '0;
				dst_q  <= '0;
				src_q  <= '0;
				ctrl_q <= '0;
				pid_q  <= '0;
				td0_q  <= '0;
				td1_q  <= '0;
				ovf_q  <= 1'b0;
			end else begin
				pos_q  <= pos_n;
				dst_q  <= dst_n;
				src_q  <= src_n;
				ctrl_q <= ctrl_n;
				pid_q  <= pid_n;
				td0_q  <= td0_n;
				td1_q  <= td1_n;
				ovf_q  <= ovf_n;
			end
		end
	end

endmodule

// File: hdl/afpf_filter.sv
// Address, control and PID filter that builds the frame summary word.
// Addresses compare like a C string compare over seven characters.
// Depends on afpf_pkg.
module afpf_filter (
	input  afpf_pkg::cfg_t      cfg,
	input  afpf_pkg::sum_t      sum,
	output afpf_pkg::out_word_t word
);
	import afpf_pkg::*;

	function automatic logic addr_differs(addr_t a, addr_t b);
		logic diff;
		logic stop;
		diff = 1'b0;
		stop = 1'b0;
		for (int k = NUM_CHARS - 1; k >= 0; k--) begin
			if (!stop) begin
				if (a[k] != b[k]) begin
					diff = 1'b1;
					stop = 1'b1;
				end else if (a[k] == '0) begin
					stop = 1'b1;
				end
			end
		end
		return diff;
	endfunction

	logic rej;

	always_comb begin
		rej = (sum.status != STATUS_OK)
			|| (cfg.filt_src_en && addr_differs(sum.src, cfg.want_src))
			|| (cfg.filt_dst_en && addr_differs(sum.dst, cfg.want_dst))
			|| (cfg.filt_ctrl_en && (sum.ctrl != cfg.want_ctrl))
			|| (cfg.filt_pid_en && (sum.pid != cfg.want_pid));

		word.kind                = KIND_SUMMARY;
		word.payload_byte        = '0;
		word.destination_address = sum.dst;
		word.source_address      = sum.src;
		word.control_field       = sum.ctrl;
		word.pid_field           = sum.pid;
		word.payload_length      = sum.length;
		word.rejected            = rej;
		word.status              = sum.status;
		word.last                = 1'b1;
	end

endmodule

// File: hdl/afpf_outq.sv
// Output register with one extra slot for a summary that follows a payload word.
// Tells the front end when it may hand over the next input word.
// Depends on afpf_pkg.
module afpf_outq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push_pay,
	input  logic [afpf_pkg::BYTE_W-1:0] pay_byte,
	input  logic                        push_sum,
	input  afpf_pkg::out_word_t         sum_word,
	input  logic                        out_ready,
	output logic                        out_valid,
	output afpf_pkg::out_word_t         out_word,
	output logic                        can_take
);
	import afpf_pkg::*;

	logic      out_v_q, extra_v_q;
	out_word_t out_q, extra_q, pay_word;
	logic      adv;

	always_comb begin
		pay_word              = '0;
		pay_word.kind         = KIND_PAYLOAD;
		pay_word.payload_byte = pay_byte;
		adv       = !out_v_q || out_ready;
		can_take  = adv && !extra_v_q;
		out_valid = out_v_q;
		out_word  = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			extra_v_q <= 1'b0;
		end else if (adv) begin
			if (extra_v_q) begin
				out_v_q   <= 1'b1;
				extra_v_q <= 1'b0;
			end else begin
				out_v_q   <= push_pay || push_sum;
				extra_v_q <= push_pay && push_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (extra_v_q) begin
				out_q <= extra_q;
			end else if (push_pay) begin
				out_q   <= pay_word;
				extra_q <= sum_word;
			end else if (push_sum) begin
				out_q <= sum_word;
			end
		end
	end

endmodule

// File: hdl/afpf_checker.sv
// Port-level checks for the AX.25 frame parser top level, and the bind that attaches them.
// Depends on afpf_pkg and ax25_frame_parse_filter_top.
module afpf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input afpf_pkg::out_word_t out_word
);
	import afpf_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	a_pay_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.kind == KIND_PAYLOAD) |->
			!out_word.last && !out_word.rejected && (out_word.payload_length == '0))
		else $error("payload word carries summary fields");

	a_sum_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.kind == KIND_SUMMARY) && (out_word.status != STATUS_OK) |->
			out_word.rejected && out_word.last)
		else $error("bad frame summary not rejected");

	a_short_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.kind == KIND_SUMMARY) && (out_word.status == STATUS_SHORT) |->
			(out_word.payload_length == '0))
		else $error("short frame reports payload");

endmodule

bind ax25_frame_parse_filter_top afpf_checker u_afpf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_word (out_word)
);

// File: tb/tb_ax25_frame_parse_filter_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for ax25_frame_parse_filter_top: random AX.25 frames against a
// frame decoder and filter predictor, with random gaps on both channels.
// Depends on afpf_pkg and the RTL under hdl/.
module tb_ax25_frame_parse_filter_top;
	import afpf_pkg::*;

	localparam int unsigned FRAME_LIMIT = DEF_MAX_FRAME;
	localparam int BYTES_PER_PHASE = 120;
	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_REPORTS = 40;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_word_t             in_word = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_word_t            out_word;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_wdata = '0;

	in_word_t  pending_bytes[$];
	out_word_t expected_words[$];

	cfg_t              shadow_cfg = '0;
	logic [10:0]       frame_len = '0;
	addr_t             dst_acc = '0;
	addr_t             src_acc = '0;
	logic [BYTE_W-1:0] ctrl_acc = '0;
	logic [BYTE_W-1:0] pid_acc = '0;
	logic [BYTE_W-1:0] tail_bytes [2] = '{default: '0};
	logic              truncated = 1'b0;

	int        send_gap = 0;
	int        stall_left = 0;
	bit        quiet_in = 1'b0;
	bit        quiet_out = 1'b0;
	int        idle_cycles = 0;
	int        errors = 0;
	int        payload_seen = 0;
	int        summaries_seen = 0;
	int        rejected_seen = 0;
	int        short_seen = 0;
	int        long_seen = 0;
	int        settings_used = 1;
	out_word_t oldest;

	ax25_frame_parse_filter_top #(
		.MAX_FRAME(FRAME_LIMIT)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Address compare in the manner of strcmp: stops once both characters are zero.
	function automatic logic addr_mismatch(addr_t a, addr_t b);
		for (int k = 0; k < NUM_CHARS; k++) begin
			if (a[NUM_CHARS-1-k] != b[NUM_CHARS-1-k]) return 1'b1;
			if (a[NUM_CHARS-1-k] == '0) return 1'b0;
		end
		return 1'b0;
	endfunction

	function automatic void clear_frame_state();
		frame_len = '0;
		dst_acc = '0;
		src_acc = '0;
		ctrl_acc = '0;
		pid_acc = '0;
		tail_bytes[0] = '0;
		tail_bytes[1] = '0;
		truncated = 1'b0;
	endfunction

	function automatic void decode_frame_byte(in_word_t w);
		out_word_t  o;
		int         pos;
		logic [1:0] st;
		logic       rej;
		pos = int'(frame_len);
		if (pos >= FRAME_LIMIT) begin
			truncated = 1'b1;
		end else begin
			if (pos < NUM_CHARS) begin
				dst_acc[NUM_CHARS-1-pos] = w.frame_byte[BYTE_W-1:1];
			end else if (pos < 2 * NUM_CHARS) begin
				src_acc[2*NUM_CHARS-1-pos] = w.frame_byte[BYTE_W-1:1];
			end else if (pos == CTRL_POS) begin
				ctrl_acc = w.frame_byte;
			end else if (pos == PID_POS) begin
				pid_acc = w.frame_byte;
			end else begin
				// A byte is payload only once the two FCS candidates behind it have arrived.
				if (pos >= MIN_FRAME) begin
					o = '0;
					o.kind = KIND_PAYLOAD;
					o.payload_byte = tail_bytes[0];
					expected_words.push_back(o);
				end
				tail_bytes[0] = tail_bytes[1];
				tail_bytes[1] = w.frame_byte;
			end
			frame_len = frame_len + 1'b1;
		end
		if (w.end_of_frame) begin
			st = STATUS_OK;
			if (truncated) st = STATUS_LONG;
			else if (frame_len < MIN_FRAME) st = STATUS_SHORT;
			rej = (st != STATUS_OK);
			if (shadow_cfg.filt_src_en && addr_mismatch(src_acc, shadow_cfg.want_src)) rej = 1'b1;
			if (shadow_cfg.filt_dst_en && addr_mismatch(dst_acc, shadow_cfg.want_dst)) rej = 1'b1;
			if (shadow_cfg.filt_ctrl_en && ctrl_acc != shadow_cfg.want_ctrl) rej = 1'b1;
			if (shadow_cfg.filt_pid_en && pid_acc != shadow_cfg.want_pid) rej = 1'b1;
			o = '0;
			o.kind = KIND_SUMMARY;
			o.destination_address = dst_acc;
			o.source_address = src_acc;
			o.control_field = ctrl_acc;
			o.pid_field = pid_acc;
			o.payload_length = (frame_len >= MIN_FRAME) ? PLEN_W'(frame_len - MIN_FRAME) : '0;
			o.rejected = rej;
			o.status = st;
			o.last = 1'b1;
			expected_words.push_back(o);
			clear_frame_state();
		end
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	function automatic void check_word(out_word_t want, out_word_t got);
		check_field("kind", 64'(want.kind), 64'(got.kind));
		check_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
		check_field("destination_address", 64'(want.destination_address),
			64'(got.destination_address));
		check_field("source_address", 64'(want.source_address), 64'(got.source_address));
		check_field("control_field", 64'(want.control_field), 64'(got.control_field));
		check_field("pid_field", 64'(want.pid_field), 64'(got.pid_field));
		check_field("payload_length", 64'(want.payload_length), 64'(got.payload_length));
		check_field("rejected", 64'(want.rejected), 64'(got.rejected));
		check_field("status", 64'(want.status), 64'(got.status));
		check_field("last", 64'(want.last), 64'(got.last));
	endfunction

	// Mostly back to back, sometimes a short gap, now and then a long pause.
	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if ($urandom_range(0, 149) == 0) quiet_in <= 1'($urandom_range(0, 1));
		if ($urandom_range(0, 149) == 0) quiet_out <= 1'($urandom_range(0, 1));
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) decode_frame_byte(in_word);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					in_word <= pending_bytes.pop_front();
					in_valid <= 1'b1;
					send_gap <= pick_gap(quiet_in);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected output word, expected none, got %h",
							$time, out_word);
				end else begin
					oldest = expected_words.pop_front();
					check_word(oldest, out_word);
					if (oldest.kind == KIND_SUMMARY) begin
						summaries_seen++;
						if (oldest.rejected) rejected_seen++;
						if (oldest.status == STATUS_SHORT) short_seen++;
						if (oldest.status == STATUS_LONG) long_seen++;
					end else begin
						payload_seen++;
					end
				end
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!quiet_out && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				stall_left <= pick_gap(1'b0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d words still expected",
				$time, idle_cycles, expected_words.size());
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [ADDR_W-1:0] junk_bits();
		return ADDR_W'({$urandom, $urandom});
	endfunction

	function automatic addr_t rand_addr();
		addr_t a;
		int    sel;
		sel = $urandom_range(0, 9);
		for (int k = 0; k < NUM_CHARS; k++) a[k] = CHAR_W'($urandom_range(1, 127));
		if (sel < 6) a[NUM_CHARS-1-$urandom_range(0, NUM_CHARS-1)] = '0;
		else if (sel == 6) a = '0;
		else if (sel == 7) a = '1;
		return a;
	endfunction

	function automatic logic [BYTE_W-1:0] rand_field();
		int sel;
		sel = $urandom_range(0, 5);
		if (sel == 0) return '0;
		if (sel == 1) return '1;
		return BYTE_W'($urandom);
	endfunction

	// Address for a frame: often the wanted one, sometimes with garbage after its
	// terminating zero, sometimes one character off, sometimes unrelated.
	function automatic addr_t frame_addr(addr_t want);
		addr_t a;
		int    sel;
		int    first_zero;
		a = want;
		sel = $urandom_range(0, 9);
		first_zero = NUM_CHARS;
		for (int k = NUM_CHARS - 1; k >= 0; k--)
			if (a[NUM_CHARS-1-k] == '0) first_zero = k;
		if (sel >= 4 && sel < 6) begin
			for (int k = first_zero + 1; k < NUM_CHARS; k++)
				a[NUM_CHARS-1-k] = CHAR_W'($urandom);
		end else if (sel >= 6 && sel < 8) begin
			a[$urandom_range(0, NUM_CHARS-1)] ^= CHAR_W'(1 << $urandom_range(0, CHAR_W-1));
		end else if (sel >= 8) begin
			a = rand_addr();
		end
		return a;
	endfunction

	task automatic push_byte(logic [BYTE_W-1:0] b, logic eof);
		in_word_t w;
		w.frame_byte = b;
		w.end_of_frame = eof;
		pending_bytes.push_back(w);
	endtask

	task automatic push_frame(int len);
		addr_t             dst;
		addr_t             src;
		logic [BYTE_W-1:0] ctrl;
		logic [BYTE_W-1:0] pid;
		logic [BYTE_W-1:0] b;
		dst = frame_addr(shadow_cfg.want_dst);
		src = frame_addr(shadow_cfg.want_src);
		ctrl = ($urandom_range(0, 3) != 0) ? shadow_cfg.want_ctrl : rand_field();
		pid = ($urandom_range(0, 3) != 0) ? shadow_cfg.want_pid : rand_field();
		for (int pos = 0; pos < len; pos++) begin
			b = BYTE_W'($urandom);
			if (pos < NUM_CHARS) b[BYTE_W-1:1] = dst[NUM_CHARS-1-pos];
			else if (pos < 2 * NUM_CHARS) b[BYTE_W-1:1] = src[2*NUM_CHARS-1-pos];
			else if (pos == CTRL_POS) b = ctrl;
			else if (pos == PID_POS) b = pid;
			push_byte(b, pos == len - 1);
		end
	endtask

	task automatic push_random_frames(int budget);
		int sent;
		int r;
		int len;
		sent = 0;
		while (sent < budget) begin
			r = $urandom_range(0, 99);
			if (r < 12) len = $urandom_range(1, MIN_FRAME - 1);
			else if (r < 85) len = $urandom_range(MIN_FRAME, 34);
			else len = $urandom_range(35, 80);
			push_frame(len);
			sent += len;
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_bytes.size() > 0 || in_valid || expected_words.size() > 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Upper data bits beyond each register's width carry noise; the block must drop them.
	task automatic program_cfg(cfg_t c);
		logic [ADDR_W-1:0] wdata_of [8];
		wdata_of[REG_FILT_SRC_EN] = ADDR_W'({junk_bits() >> 1, c.filt_src_en});
		wdata_of[REG_FILT_DST_EN] = ADDR_W'({junk_bits() >> 1, c.filt_dst_en});
		wdata_of[REG_FILT_CTRL_EN] = ADDR_W'({junk_bits() >> 1, c.filt_ctrl_en});
		wdata_of[REG_FILT_PID_EN] = ADDR_W'({junk_bits() >> 1, c.filt_pid_en});
		wdata_of[REG_WANT_SRC] = c.want_src;
		wdata_of[REG_WANT_DST] = c.want_dst;
		wdata_of[REG_WANT_CTRL] = ADDR_W'({junk_bits() >> BYTE_W, c.want_ctrl});
		wdata_of[REG_WANT_PID] = ADDR_W'({junk_bits() >> BYTE_W, c.want_pid});
		for (int i = 0; i < $size(wdata_of); i++) begin
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_wdata <= wdata_of[i];
		end
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_cfg = c;
		settings_used++;
	endtask

	function automatic cfg_t rand_cfg();
		cfg_t c;
		c.filt_src_en = 1'($urandom_range(0, 1));
		c.filt_dst_en = 1'($urandom_range(0, 1));
		c.filt_ctrl_en = 1'($urandom_range(0, 1));
		c.filt_pid_en = 1'($urandom_range(0, 1));
		c.want_src = rand_addr();
		c.want_dst = rand_addr();
		c.want_ctrl = rand_field();
		c.want_pid = rand_field();
		return c;
	endfunction

	initial begin : stimulus
		cfg_t c;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: a lone final byte, then a frame of extreme bytes with one payload byte.
		push_byte(8'hFF, 1'b1);
		for (int pos = 0; pos < HEADER_BYTES; pos++)
			push_byte((pos < NUM_CHARS || pos == CTRL_POS) ? 8'hFF : 8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h01, 1'b1);
		push_random_frames(BYTES_PER_PHASE);
		wait_idle();

		for (int phase = 1; phase <= 6; phase++) begin
			c = rand_cfg();
			if (phase <= 2) begin
				c.filt_src_en = 1'b1;
				c.filt_dst_en = 1'b1;
				c.filt_ctrl_en = 1'b1;
				c.filt_pid_en = 1'b1;
				c.want_src = (phase == 1) ? '1 : '0;
				c.want_dst = (phase == 1) ? '1 : '0;
				c.want_ctrl = (phase == 1) ? '1 : '0;
				c.want_pid = (phase == 1) ? '1 : '0;
			end
			program_cfg(c);
			push_random_frames(BYTES_PER_PHASE);
			wait_idle();
		end

		if (expected_words.size() > 0) begin
			errors += expected_words.size();
			$display("%0t: %0d expected words never arrived", $time, expected_words.size());
		end
		$display("Checked %0d payload bytes and %0d frame summaries over %0d register settings.",
			payload_seen, summaries_seen, settings_used);
		$display("Summaries: %0d rejected, %0d too short, %0d truncated; %0d errors.",
			rejected_seen, short_seen, long_seen, errors);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
